@@ design/altf_pkg.sv @@
// ----------------------------------------------------------------------------
// altf_pkg: shared types and constants for the tilt angle block
// Angle table, output limits and the control word that moves along the
// CORDIC cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package altf_pkg;

  // Guard bits added below the operands before the first rotation.
  localparam int GUARD_BITS = 16;
  // Angle accumulator, in units of 1/32768 degree.
  localparam int ANGLE_W = 25;
  // Width of the accumulator after rounding to 1/128 degree.
  localparam int RND_W = ANGLE_W - 7;
  localparam int MAX_STEPS = 24;

  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;

  localparam logic signed [RND_W-1:0] ROLL_LIMIT  = RND_W'(23040);
  localparam logic signed [RND_W-1:0] PITCH_LIMIT = RND_W'(11520);

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(2949120);

  // Entry i is round(atan(2^-i) * 180/pi * 32768).
  localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [MAX_STEPS] = '{
    ANGLE_W'(1474560), ANGLE_W'(870484), ANGLE_W'(459940), ANGLE_W'(233473),
    ANGLE_W'(117189),  ANGLE_W'(58652),  ANGLE_W'(29333),  ANGLE_W'(14667),
    ANGLE_W'(7334),    ANGLE_W'(3667),   ANGLE_W'(1833),   ANGLE_W'(917),
    ANGLE_W'(458),     ANGLE_W'(229),    ANGLE_W'(115),    ANGLE_W'(57),
    ANGLE_W'(29),      ANGLE_W'(14),     ANGLE_W'(7),      ANGLE_W'(4),
    ANGLE_W'(2),       ANGLE_W'(1),      ANGLE_W'(0),      ANGLE_W'(0)
  };

  // Control word carried beside the data through the cell row.
  typedef struct packed {
    logic valid;
    logic pitch;  // high for the pitch request, low for roll
  } ctl_t;

endpackage

`default_nettype wire

@@ design/accel_lowpass_tilt_angles.sv @@
// ----------------------------------------------------------------------------
// accel_lowpass_tilt_angles: low-pass filtered roll and pitch from an
// accelerometer
// Each request carries one raw sample of the three axes. Every axis is
// averaged with its previous filtered value (alpha one half, 8 fraction bits
// by default), and the block returns roll = atan2(-y, z) and
// pitch = atan2(x, sqrt(y*y + z*z)) in 1/128 degree, one result per sample.
// One sample is worked on at a time. The time to a result is set by the
// bit-serial square root, which produces one bit per cycle, followed by the
// pitch pass through the row of CORDIC cells; the roll pass runs in the
// shadow of the square root. A finished result waits in the output
// register, so the next sample can be accepted while it is still unread.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_lowpass_tilt_angles #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // roll_angle [15:0], pitch_angle [30:16], zero [31]
);
  import altf_pkg::*;

  localparam int W  = 16 + FRACTION_BITS;
  localparam int OW = W + 1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LAUNCH   = 3'd1;
  localparam logic [2:0] ST_WAIT_MAG = 3'd2;
  localparam logic [2:0] ST_WAIT_OUT = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  logic [2:0] state_q, state_d;

  logic signed [W-1:0] fx_q, fy_q, fz_q;
  logic signed [W-1:0] fx_d, fy_d, fz_d;
  logic signed [W:0]   sum_x, sum_y, sum_z;
  logic                in_fire;

  logic                roll_neg_q, roll_zero_q, pitch_zero_q;
  logic signed [ROLL_W-1:0]  roll_q;
  logic signed [PITCH_W-1:0] pitch_q;

  logic                out_valid_q, out_valid_d;
  logic [31:0]         out_data_q;
  logic                out_load;

  ctl_t                launch_ctl;
  logic signed [OW-1:0] launch_s, launch_c;
  ctl_t                res_ctl;
  logic signed [ANGLE_W-1:0] res_acc;

  logic                mag_done;
  logic [W-1:0]        mag;

  function automatic logic signed [ROLL_W-1:0] round_clamp(
    input logic signed [ANGLE_W-1:0] acc,
    input logic signed [RND_W-1:0]   limit
  );
    logic [ANGLE_W:0]        sum;
    logic signed [RND_W-1:0] r;
    sum = {acc[ANGLE_W-1], acc} + (ANGLE_W+1)'(128);
    r   = sum[ANGLE_W:8];
    if (r > limit) begin
      r = limit;
    end else if (r < -limit) begin
      r = -limit;
    end
    return ROLL_W'(r);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // filtered = floor((sample * 2^FRACTION_BITS + filtered) / 2)
  assign sum_x = ((W+1)'($signed(s_axis_tdata[15:0]))  <<< FRACTION_BITS) + (W+1)'(fx_q);
  assign sum_y = ((W+1)'($signed(s_axis_tdata[31:16])) <<< FRACTION_BITS) + (W+1)'(fy_q);
  assign sum_z = ((W+1)'($signed(s_axis_tdata[47:32])) <<< FRACTION_BITS) + (W+1)'(fz_q);
  assign fx_d  = sum_x[W:1];
  assign fy_d  = sum_y[W:1];
  assign fz_d  = sum_z[W:1];

  // Roll enters the row right after filtering, pitch once the magnitude is known.
  always_comb begin
    launch_ctl.valid = (state_q == ST_LAUNCH) || (state_q == ST_WAIT_MAG && mag_done);
    launch_ctl.pitch = (state_q == ST_WAIT_MAG);
    if (state_q == ST_WAIT_MAG) begin
      launch_s = OW'(fx_q);
      launch_c = $signed({1'b0, mag});
    end else begin
      launch_s = -OW'(fy_q);
      launch_c = OW'(fz_q);
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_LAUNCH;
      ST_LAUNCH:   state_d = ST_WAIT_MAG;
      ST_WAIT_MAG: if (mag_done) state_d = ST_WAIT_OUT;
      ST_WAIT_OUT: if (res_ctl.valid && res_ctl.pitch) state_d = ST_DONE;
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      fx_q        <= '0;
      fy_q        <= '0;
      fz_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        fx_q <= fx_d;
        fy_q <= fy_d;
        fz_q <= fz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LAUNCH) begin
      // A zero y with negative z gives -180 degrees, as a negated zero would.
      roll_neg_q  <= (fy_q == '0) && fz_q[W-1];
      roll_zero_q <= (fy_q == '0) && (fz_q == '0);
    end
    if (state_q == ST_WAIT_MAG && mag_done) begin
      pitch_zero_q <= (fx_q == '0) && (mag == '0);
    end
    if (res_ctl.valid && !res_ctl.pitch) begin
      if (roll_neg_q) begin
        roll_q <= -ROLL_W'(ROLL_LIMIT);
      end else if (roll_zero_q) begin
        roll_q <= '0;
      end else begin
        roll_q <= round_clamp(res_acc, ROLL_LIMIT);
      end
    end
    if (res_ctl.valid && res_ctl.pitch) begin
      if (pitch_zero_q) begin
        pitch_q <= '0;
      end else begin
        pitch_q <= PITCH_W'(round_clamp(res_acc, PITCH_LIMIT));
      end
    end
    if (out_load) begin
      out_data_q <= {1'b0, pitch_q, roll_q};
    end
  end

  altf_mag #(
    .W(W)
  ) u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_LAUNCH),
    .y_i    (fy_q),
    .z_i    (fz_q),
    .done_o (mag_done),
    .mag_o  (mag)
  );

  altf_cordic_chain #(
    .OW   (OW),
    .STEPS(CORDIC_STEPS)
  ) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (launch_ctl),
    .s_i   (launch_s),
    .c_i   (launch_c),
    .ctl_o (res_ctl),
    .acc_o (res_acc)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ design/altf_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// altf_cordic_cell: one vectoring step of the CORDIC row
// Rotates the vector toward the x axis by atan(2^-SHIFT) and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module altf_cordic_cell #(
  parameter int CW    = 44,
  parameter int SHIFT = 0
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire altf_pkg::ctl_t                  ctl_i,
  input  wire logic signed [CW-1:0]            x_i,
  input  wire logic signed [CW-1:0]            y_i,
  input  wire logic signed [altf_pkg::ANGLE_W-1:0] acc_i,
  output altf_pkg::ctl_t                       ctl_o,
  output logic signed [CW-1:0]                 x_o,
  output logic signed [CW-1:0]                 y_o,
  output logic signed [altf_pkg::ANGLE_W-1:0]  acc_o
);
  import altf_pkg::*;

  ctl_t                      ctl_q;
  logic signed [CW-1:0]      x_q, x_d;
  logic signed [CW-1:0]      y_q, y_d;
  logic signed [ANGLE_W-1:0] acc_q, acc_d;
  logic signed [CW-1:0]      dx, dy;

  assign dx = y_i >>> SHIFT;
  assign dy = x_i >>> SHIFT;

  always_comb begin
    if (!y_i[CW-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      acc_d = acc_i + ATAN_TABLE[SHIFT];
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      acc_d = acc_i - ATAN_TABLE[SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

@@ design/altf_cordic_chain.sv @@
// ----------------------------------------------------------------------------
// altf_cordic_chain: CORDIC vectoring row
// An entry stage scales the operands and folds the left half plane onto
// the right one; a row of cells then drives the vector onto the x axis.
// ----------------------------------------------------------------------------
`default_nettype none

module altf_cordic_chain #(
  parameter int OW    = 25,
  parameter int STEPS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire altf_pkg::ctl_t                  ctl_i,
  input  wire logic signed [OW-1:0]            s_i,
  input  wire logic signed [OW-1:0]            c_i,
  output altf_pkg::ctl_t                       ctl_o,
  output logic signed [altf_pkg::ANGLE_W-1:0]  acc_o
);
  import altf_pkg::*;

  // Room for the guard bits and the CORDIC gain.
  localparam int CW = OW + GUARD_BITS + 3;

  ctl_t                      ctl_w [STEPS+1];
  logic signed [CW-1:0]      x_w   [STEPS+1];
  logic signed [CW-1:0]      y_w   [STEPS+1];
  logic signed [ANGLE_W-1:0] acc_w [STEPS+1];

  ctl_t                      ctl_q;
  logic signed [CW-1:0]      x_q, x_d;
  logic signed [CW-1:0]      y_q, y_d;
  logic signed [ANGLE_W-1:0] acc_q, acc_d;
  logic signed [CW-1:0]      sx, cx;

  assign sx = CW'(s_i) <<< GUARD_BITS;
  assign cx = CW'(c_i) <<< GUARD_BITS;

  // A negative cosine operand is first turned by a quarter turn.
  always_comb begin
    if (!c_i[OW-1]) begin
      x_d   = cx;
      y_d   = sx;
      acc_d = '0;
    end else if (!s_i[OW-1]) begin
      x_d   = sx;
      y_d   = -cx;
      acc_d = QUARTER_TURN;
    end else begin
      x_d   = -sx;
      y_d   = cx;
      acc_d = -QUARTER_TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign ctl_w[0] = ctl_q;
  assign x_w[0]   = x_q;
  assign y_w[0]   = y_q;
  assign acc_w[0] = acc_q;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    altf_cordic_cell #(
      .CW   (CW),
      .SHIFT(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_w[i]),
      .x_i   (x_w[i]),
      .y_i   (y_w[i]),
      .acc_i (acc_w[i]),
      .ctl_o (ctl_w[i+1]),
      .x_o   (x_w[i+1]),
      .y_o   (y_w[i+1]),
      .acc_o (acc_w[i+1])
    );
  end

  assign ctl_o = ctl_w[STEPS];
  assign acc_o = acc_w[STEPS];

endmodule

`default_nettype wire

@@ design/altf_mag.sv @@
// ----------------------------------------------------------------------------
// altf_mag: magnitude of the filtered y and z axes
// Squares both axes, adds them and takes the floor square root one result
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module altf_mag #(
  parameter int W = 24
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire logic signed [W-1:0] y_i,
  input  wire logic signed [W-1:0] z_i,
  output logic                    done_o,
  output logic [W-1:0]            mag_o
);

  localparam int CNT_W = $clog2(W);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SQR  = 2'd1;
  localparam logic [1:0] M_SUM  = 2'd2;
  localparam logic [1:0] M_ITER = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [W-1:0]   ay_q, az_q;
  logic [2*W-1:0] sq_y_q, sq_z_q;
  logic [2*W-1:0] rad_q, rad_d;
  logic [W:0]     rem_q, rem_d;
  logic [W-1:0]   root_q, root_d;

  logic [W+2:0]   rem_sh;
  logic [W+2:0]   trial;
  logic           fits;

  assign rem_sh = {rem_q, rad_q[2*W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          state_d = M_SQR;
        end
      end
      M_SQR: begin
        state_d = M_SUM;
      end
      M_SUM: begin
        rad_d   = sq_y_q + sq_z_q;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = M_ITER;
      end
      M_ITER: begin
        rad_d  = rad_q << 2;
        rem_d  = fits ? (W+1)'(rem_sh - trial) : (W+1)'(rem_sh);
        root_d = {root_q[W-2:0], fits};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W-1)) begin
          done_d  = 1'b1;
          state_d = M_IDLE;
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == M_IDLE) begin
      ay_q <= y_i[W-1] ? W'(-y_i) : W'(y_i);
      az_q <= z_i[W-1] ? W'(-z_i) : W'(z_i);
    end
    sq_y_q <= ay_q * ay_q;
    sq_z_q <= az_q * az_q;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign mag_o  = root_q;

endmodule

`default_nettype wire

@@ design/altf_checker.sv @@
// ----------------------------------------------------------------------------
// altf_checker: port-level checks for the tilt angle block
// Watches the request counts, output ranges and the busy behavior after a
// sample is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module altf_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [47:0] s_axis_tdata,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata
);

  logic [1:0] pending_q;
  logic       in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Samples taken whose results have not been delivered yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 2'd0)
    else $error("result shown with no sample outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two samples in flight");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("sample taken while the previous one is still in work");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) >= -16'sd23040) &&
                      ($signed(m_axis_tdata[15:0]) <= 16'sd23040) &&
                      ($signed(m_axis_tdata[30:16]) >= -15'sd11520) &&
                      ($signed(m_axis_tdata[30:16]) <= 15'sd11520) &&
                      !m_axis_tdata[31])
    else $error("angle outside its range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind accel_lowpass_tilt_angles altf_checker u_checker (.*);

`default_nettype wire
